// ----- sv/frapq_pkg.sv -----
// Package: shared widths, reset values, operation codes and controller states.
package frapq_pkg;

  localparam int CELLS_DEFAULT = 1024;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 11;
  localparam int AMT_W   = 16;
  localparam int VAL_W   = 32;
  localparam int SIZE_W  = 11;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_UP,
    ST_GAP,
    ST_DOWN,
    ST_QOUT
  } state_t;

endpackage

// ----- sv/frapq_if.sv -----
// Interfaces: request and response channels with valid/ready handshake.
interface frapq_in_if;
  logic                                valid;
  logic                                ready;
  logic        [frapq_pkg::OP_W-1:0]   op;
  logic        [frapq_pkg::IDX_W-1:0]  index_low;
  logic        [frapq_pkg::IDX_W-1:0]  index_high;
  logic signed [frapq_pkg::AMT_W-1:0]  amount;

  modport source (output valid, op, index_low, index_high, amount, input ready);
  modport sink   (input valid, op, index_low, index_high, amount, output ready);
endinterface

interface frapq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [frapq_pkg::VAL_W-1:0]  point_value;

  modport source (output valid, point_value, input ready);
  modport sink   (input valid, point_value, output ready);
endinterface

// ----- sv/fenwick_range_add_point_query.sv -----
// Top level: range-add / point-query binary indexed tree over one synchronous memory.
// Range add: after acceptance, two upward walks, each reading and writing back one cell per
//   step and ending in a write-back and a gap state; the second starts at index_high+1.
// Point query: after acceptance, a downward walk reads one cell per set bit, adds the last cell, then loads the result.
// Clear: after acceptance, zeroes each cell in use in turn. One transaction at a time.
// Reset: a clearing pass over all CELLS cells zeroes the memory; no request is taken meanwhile.
module fenwick_range_add_point_query #(
  parameter int CELLS = frapq_pkg::CELLS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [frapq_pkg::SIZE_W-1:0]  cfg_data,
  frapq_in_if.sink                      req,
  frapq_out_if.source                   rsp
);

  // Memory address width, and walk position width: a position may step to
  // twice the cell count, and the second walk of an add starts at up to 2048.
  localparam int AW  = $clog2(CELLS);
  localparam int PW  = ($clog2(CELLS) + 2 > 12) ? $clog2(CELLS) + 2 : 12;
  localparam int VW  = frapq_pkg::VAL_W;

  // Configuration register.
  logic [frapq_pkg::SIZE_W-1:0] size_in_use;

  // Controller state.
  frapq_pkg::state_t state, state_next;

  // Walk registers.
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] cnt, cnt_next;
  logic [PW-1:0] second_pos, second_pos_next;
  logic          second, second_next;
  logic [VW-1:0] delta, delta_next;
  logic [VW-1:0] second_delta, second_delta_next;
  logic [VW-1:0] acc, acc_next;

  // Pending read: data returns next cycle, either to write back or to accumulate.
  logic          upd_pend, upd_pend_next;
  logic          qry_pend, qry_pend_next;
  logic [AW-1:0] daddr, daddr_next;

  // Memory and its ports.
  logic [VW-1:0] mem [CELLS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [VW-1:0] mem_wdata, rdata;

  // Response register.
  logic          out_load;
  logic          rsp_valid;
  logic [VW-1:0] rsp_value;

  // Derived values.
  logic [PW-1:0] size_ext, lim, lowbit, lo_ext;
  logic          accept, up_step;
  logic [VW-1:0] amt_ext;

  assign size_ext = PW'(size_in_use);
  // Clip the size in use to the tree.
  assign lim      = (size_ext > PW'(CELLS)) ? PW'(CELLS) : size_ext;
  assign lowbit   = pos & (~pos + PW'(1));
  assign lo_ext   = PW'(req.index_low);
  assign up_step  = (pos != '0) && (pos <= lim);
  assign amt_ext  = VW'(req.amount);
  assign accept   = req.valid && req.ready;

  assign req.ready       = (state == frapq_pkg::ST_IDLE);
  assign rsp.valid       = rsp_valid;
  assign rsp.point_value = rsp_value;

  // Configuration write.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= frapq_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      size_in_use <= cfg_data;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      frapq_pkg::ST_INIT: begin
        if (cnt == PW'(CELLS - 1)) state_next = frapq_pkg::ST_IDLE;
      end
      frapq_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.op)
            frapq_pkg::OP_CLEAR: state_next = frapq_pkg::ST_CLEAR;
            frapq_pkg::OP_ADD:   state_next = frapq_pkg::ST_UP;
            frapq_pkg::OP_QUERY: state_next = frapq_pkg::ST_DOWN;
            default:             state_next = frapq_pkg::ST_IDLE;
          endcase
        end
      end
      frapq_pkg::ST_CLEAR: begin
        if (cnt >= lim) state_next = frapq_pkg::ST_IDLE;
      end
      frapq_pkg::ST_UP: begin
        // Walk done: any last cell read is written back, then move to the gap state.
        if (!up_step) state_next = frapq_pkg::ST_GAP;
      end
      frapq_pkg::ST_GAP: begin
        state_next = second ? frapq_pkg::ST_IDLE : frapq_pkg::ST_UP;
      end
      frapq_pkg::ST_DOWN: begin
        if (pos == '0) state_next = frapq_pkg::ST_QOUT;
      end
      frapq_pkg::ST_QOUT: begin
        if (!rsp_valid || rsp.ready) state_next = frapq_pkg::ST_IDLE;
      end
      default: state_next = frapq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    pos_next          = pos;
    cnt_next          = cnt;
    second_pos_next   = second_pos;
    second_next       = second;
    delta_next        = delta;
    second_delta_next = second_delta;
    acc_next          = acc;
    daddr_next        = daddr;
    upd_pend_next     = 1'b0;
    qry_pend_next     = 1'b0;
    out_load          = 1'b0;
    mem_re            = 1'b0;
    mem_raddr         = AW'(pos - PW'(1));

    // Write back the cell read last cycle with the walk's delta added.
    mem_we    = upd_pend;
    mem_waddr = daddr;
    mem_wdata = rdata + delta;

    if (qry_pend) acc_next = acc + rdata;

    case (state)
      frapq_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = '0;
        cnt_next  = cnt + PW'(1);
      end
      frapq_pkg::ST_IDLE: begin
        if (accept) begin
          cnt_next = '0;
          case (req.op)
            frapq_pkg::OP_ADD: begin
              pos_next          = lo_ext;
              delta_next        = amt_ext;
              second_pos_next   = PW'(req.index_high) + PW'(1);
              second_delta_next = VW'(0) - amt_ext;
              second_next       = 1'b0;
            end
            frapq_pkg::OP_QUERY: begin
              // Saturate the position to the size in use.
              pos_next = (lo_ext > lim) ? lim : lo_ext;
              acc_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      frapq_pkg::ST_CLEAR: begin
        if (cnt < lim) begin
          mem_we    = 1'b1;
          mem_waddr = cnt[AW-1:0];
          mem_wdata = '0;
          cnt_next  = cnt + PW'(1);
        end
      end
      frapq_pkg::ST_UP: begin
        if (up_step) begin
          mem_re        = 1'b1;
          daddr_next    = mem_raddr;
          upd_pend_next = 1'b1;
          pos_next      = pos + lowbit;
        end
      end
      frapq_pkg::ST_GAP: begin
        // Load the second walk only after the first one's last write lands.
        if (!second) begin
          pos_next    = second_pos;
          delta_next  = second_delta;
          second_next = 1'b1;
        end
      end
      frapq_pkg::ST_DOWN: begin
        if (pos != '0) begin
          mem_re        = 1'b1;
          qry_pend_next = 1'b1;
          pos_next      = pos ^ lowbit;
        end
      end
      frapq_pkg::ST_QOUT: begin
        if (!rsp_valid || rsp.ready) out_load = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= frapq_pkg::ST_INIT;
      cnt      <= '0;
      second   <= 1'b0;
      upd_pend <= 1'b0;
      qry_pend <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      second   <= second_next;
      upd_pend <= upd_pend_next;
      qry_pend <= qry_pend_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pos          <= pos_next;
    second_pos   <= second_pos_next;
    delta        <= delta_next;
    second_delta <= second_delta_next;
    acc          <= acc_next;
    daddr        <= daddr_next;
  end

  // Tree memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_raddr];
  end

  // Response register: hold until taken, load when free or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) rsp_value <= acc;
  end

endmodule

// ----- sim/fenwick_range_add_point_query_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the range-add / point-query binary indexed tree.
module fenwick_range_add_point_query_tb;
  import frapq_pkg::*;

  localparam int TREE_CELLS = CELLS_DEFAULT;
  // Op code the block must ignore: no result, no state change.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Handshake pacing: percent of cycles a side idles, and the long receiver hold-off.
  localparam int IDLE_PCT    = 12;
  localparam int HOLD_CYCLES = 300;
  // A clear walks every cell in use; it is the longest job the block can still be busy with
  // after the last query result has come back.
  localparam int DRAIN_CYCLES = TREE_CELLS + 64;

  // Tracks the tree exactly as the block should, and the query totals still owed.
  class fenwick_board;
    bit [VAL_W-1:0]  cells [0:TREE_CELLS];
    bit [SIZE_W-1:0] size_reg;
    bit [VAL_W-1:0]  totals_due [$];
    int mismatches;
    int checked;
    int n_clear, n_add, n_query, n_ignored;

    function new();
      size_reg = SIZE_RESET;
      foreach (cells[i]) cells[i] = '0;
      mismatches = 0;
      checked    = 0;
      n_clear    = 0;
      n_add      = 0;
      n_query    = 0;
      n_ignored  = 0;
    endfunction

    // Sizes above the tree act as the whole tree.
    function int unsigned span();
      return (size_reg > TREE_CELLS) ? TREE_CELLS : size_reg;
    endfunction

    function void set_size(bit [SIZE_W-1:0] v);
      size_reg = v;
    endfunction

    // Walk upward by lowest set bit; index zero or a start past the span does nothing.
    function void bump_upward(int unsigned pos, bit [VAL_W-1:0] delta);
      int unsigned lim;
      lim = span();
      if (pos == 0) return;
      while (pos <= lim) begin
        cells[pos] += delta;
        pos += pos & (0 - pos);
      end
    endfunction

    // Walk downward clearing the lowest set bit; positions past the span saturate.
    function bit [VAL_W-1:0] prefix_total(int unsigned pos);
      int unsigned lim;
      bit [VAL_W-1:0] acc;
      lim = span();
      acc = '0;
      if (pos > lim) pos = lim;
      while (pos != 0) begin
        acc += cells[pos];
        pos ^= pos & (0 - pos);
      end
      return acc;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] lo,
                               logic [IDX_W-1:0] hi, logic signed [AMT_W-1:0] amt);
      int unsigned lim;
      bit [VAL_W-1:0] delta;
      lim   = span();
      delta = 32'(amt);
      case (op)
        OP_CLEAR: begin
          for (int i = 1; i <= lim; i++) cells[i] = '0;
          n_clear++;
        end
        OP_ADD: begin
          bump_upward(int'(lo), delta);
          bump_upward(int'(hi) + 1, 0 - delta);
          n_add++;
        end
        OP_QUERY: begin
          totals_due.insert(totals_due.size(), prefix_total(int'(lo)));
          n_query++;
        end
        default: n_ignored++;
      endcase
    endfunction

    function void check_point(logic signed [VAL_W-1:0] got);
      bit [VAL_W-1:0] want;
      if (totals_due.size() == 0) begin
        $error("point_value: result with no query waiting, expected none, actual %0d", got);
        mismatches++;
        return;
      end
      want = totals_due.pop_front();
      checked++;
      if (got !== want) begin
        $error("point_value: expected %0d, actual %0d", $signed(want), got);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_data;

  frapq_in_if  req_bus ();
  frapq_out_if rsp_bus ();

  fenwick_range_add_point_query #(.CELLS(TREE_CELLS)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  fenwick_board board = new();

  // Pacing controls shared by the sender and the receiver processes.
  bit steady_flow   = 1'b0;
  bit hold_off_req  = 1'b0;
  int hold_offs     = 0;
  int sizes_visited = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drive one request at the falling edge and hold it until the block takes it.
  // The caller is at a falling edge; return at the falling edge after acceptance so
  // valid is only touched once per time step.
  task automatic send_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] lo,
                          logic [IDX_W-1:0] hi, logic signed [AMT_W-1:0] amt);
    while (!steady_flow && ($urandom_range(0, 99) < IDLE_PCT)) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid      <= 1'b1;
    req_bus.op         <= op;
    req_bus.index_low  <= lo;
    req_bus.index_high <= hi;
    req_bus.amount     <= amt;
    do @(posedge clk); while (!req_bus.ready);
    board.note_request(op, lo, hi, amt);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed result, then let any clear or add finish.
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (board.totals_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Write the size register; only called with the block idle, at a falling edge.
  task automatic write_size(logic [SIZE_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we   <= 1'b0;
    board.set_size(v);
    sizes_visited++;
  endtask

  // Mostly in-range indexes, some zero, some anywhere in the field.
  function automatic logic [IDX_W-1:0] pick_index(int unsigned lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 15 || lim == 0) return IDX_W'($urandom_range(0, 2047));
    return IDX_W'($urandom_range(1, lim));
  endfunction

  function automatic logic signed [AMT_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7FFF;
    if (r < 25) return AMT_W'(int'($urandom_range(0, 15)) - 8);
    return AMT_W'($urandom_range(0, 65535));
  endfunction

  // Random mix: mostly adds and queries with real ranges, a few clears and ignored codes.
  // Ignored codes do not count toward the phase length.
  task automatic run_random(int count);
    int done;
    int unsigned r, lim, span_hi;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] lo, hi;
    done = 0;
    while (done < count) begin
      lim = board.span();
      r   = $urandom_range(0, 99);
      if (r < 4)       op = OP_CLEAR;
      else if (r < 7)  op = OP_UNUSED;
      else if (r < 52) op = OP_ADD;
      else             op = OP_QUERY;
      lo = pick_index(lim);
      if ($urandom_range(0, 1) != 0) begin
        hi = pick_index(lim);
      end else begin
        span_hi = int'(lo) + $urandom_range(0, 15);
        hi = (span_hi > 2047) ? 11'd2047 : IDX_W'(span_hi);
      end
      send_req(op, lo, hi, pick_amount());
      if (op != OP_UNUSED) done++;
    end
  endtask

  // Receiver: random backpressure, steady stretches, and one long hold-off that fills
  // the block and stalls its input while the sender keeps offering.
  initial begin
    rsp_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
        @(negedge clk);
      end
    end
  end

  // Check every result transaction against the oldest owed total.
  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) board.check_point(rsp_bus.point_value);
  end

  // Size settings per random phase, with the number of counted items in each. Some small
  // sizes are followed by larger ones so cells past a small size carry values into growth.
  int phase_size  [10] = '{1, 37, 1024, 1024, 0, 2047, 1023, 512, 2, 1024};
  int phase_items [10] = '{150, 200, 200, 150, 40, 200, 200, 200, 100, 160};

  initial begin
    int failures;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    req_bus.valid      = 1'b0;
    req_bus.op         = OP_CLEAR;
    req_bus.index_low  = '0;
    req_bus.index_high = '0;
    req_bus.amount     = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at the reset size. The block runs its clearing pass first and
    // holds ready low meanwhile; the handshake wait covers that.
    send_req(OP_QUERY,  11'd0,    11'd2047, 16'sh7FFF);  // position zero gives zero
    send_req(OP_QUERY,  11'd1,    11'd0,    16'sh0000);
    send_req(OP_ADD,    11'd1,    11'd1024, 16'sh7FFF);  // whole tree, second walk starts past size
    send_req(OP_ADD,    11'd1024, 11'd2047, 16'sh8000);  // high plus one is 2048
    send_req(OP_QUERY,  11'd1024, 11'd0,    16'sh0000);
    send_req(OP_QUERY,  11'd2047, 11'd0,    16'sh0000);  // saturates to the size
    send_req(OP_ADD,    11'd0,    11'd5,    16'sh0064);  // index zero walk skipped
    send_req(OP_ADD,    11'd10,   11'd3,    16'shFFF9);  // low above high
    send_req(OP_QUERY,  11'd3,    11'd0,    16'sh0000);
    send_req(OP_QUERY,  11'd6,    11'd0,    16'sh0000);
    send_req(OP_QUERY,  11'd10,   11'd0,    16'sh0000);
    send_req(OP_UNUSED, 11'd7,    11'd9,    16'sh1234);  // ignored code
    send_req(OP_ADD,    11'd1025, 11'd1030, 16'sh0005);  // range entirely past size
    send_req(OP_ADD,    11'd682,  11'd1365, 16'sh5555);
    send_req(OP_ADD,    11'd1365, 11'd682,  16'shAAAA);
    send_req(OP_QUERY,  11'd512,  11'd0,    16'sh0000);
    send_req(OP_QUERY,  11'd1023, 11'd0,    16'sh0000);
    send_req(OP_CLEAR,  11'd2047, 11'd2047, 16'shFFFF);
    send_req(OP_QUERY,  11'd1024, 11'd0,    16'sh0000);
    send_req(OP_ADD,    11'd2047, 11'd2047, 16'sh0001);
    send_req(OP_ADD,    11'd1,    11'd1,    16'sh8000);
    send_req(OP_QUERY,  11'd1,    11'd0,    16'sh0000);
    send_req(OP_QUERY,  11'd2,    11'd0,    16'sh0000);

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      write_size(SIZE_W'(phase_size[ph]));
      steady_flow = (ph == 2);
      if (ph == 3) hold_off_req = 1'b1;
      run_random(phase_items[ph]);
    end
    steady_flow = 1'b0;

    drain();

    failures = board.mismatches + board.totals_due.size();
    $display("Covered %0d clears, %0d range adds, %0d queries and %0d ignored codes",
             board.n_clear, board.n_add, board.n_query, board.n_ignored);
    $display("over %0d size settings; %0d totals checked, %0d long output hold-offs",
             sizes_visited, board.checked, hold_offs);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond a run made entirely of full clears under the worst stalls.
  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
sv/frapq_pkg.sv
sv/frapq_if.sv
sv/fenwick_range_add_point_query.sv
sim/fenwick_range_add_point_query_tb.sv
